[hdl/rcbs_pkg.sv]
// ----------------------------------------------------------------------------
// rcbs_pkg
// Shared constants, codes, types and helpers of the colour blob seek control.
// ----------------------------------------------------------------------------
`default_nettype none

package rcbs_pkg;

  // coordinate and accumulator widths
  localparam int COORD_BITS = 12;
  localparam int SUM_BITS   = 32;

  // fixed field widths
  localparam int COLOUR_BITS    = 8;
  localparam int SPEED_BITS     = 5;
  localparam int TICK_BITS      = 16;
  localparam int TURN_BITS      = 4;
  localparam int FRAME_BITS     = 12;
  localparam int REG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  // register reset values
  localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RESET  = FRAME_BITS'(52);
  localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RESET = FRAME_BITS'(39);
  localparam logic [TICK_BITS-1:0]  STOP_TICKS_RESET   = TICK_BITS'(20);
  localparam logic [TICK_BITS-1:0]  HOLD_TICKS_RESET   = TICK_BITS'(40);
  localparam logic [TURN_BITS-1:0]  TURN_SPEED_RESET   = TURN_BITS'(4);

  // register indexes
  localparam logic [REG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = REG_INDEX_BITS'(0);
  localparam logic [REG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = REG_INDEX_BITS'(1);
  localparam logic [REG_INDEX_BITS-1:0] REG_STOP_TICKS   = REG_INDEX_BITS'(2);
  localparam logic [REG_INDEX_BITS-1:0] REG_HOLD_TICKS   = REG_INDEX_BITS'(3);
  localparam logic [REG_INDEX_BITS-1:0] REG_TURN_SPEED   = REG_INDEX_BITS'(4);

  // input commands
  typedef enum logic [1:0] {
    CMD_PIXEL        = 2'd0,
    CMD_STEP_FRAME   = 2'd1,
    CMD_STEP_NOFRAME = 2'd2,
    CMD_UNUSED       = 2'd3
  } cmd_t;

  // reported blob colour
  typedef enum logic [1:0] {
    BLOB_NONE  = 2'd0,
    BLOB_RED   = 2'd1,
    BLOB_GREEN = 2'd2,
    BLOB_BLUE  = 2'd3
  } blob_t;

  // settings as seen by the datapath, window bounds already worked out
  typedef struct packed {
    logic [COORD_BITS-1:0] x_lo;
    logic [COORD_BITS-1:0] x_hi;
    logic [COORD_BITS-1:0] y_lo;
    logic [COORD_BITS-1:0] y_hi;
    logic [TICK_BITS-1:0]  stop_ticks;
    logic [TICK_BITS-1:0]  hold_ticks;
    logic [TURN_BITS-1:0]  turn_speed;
  } cfg_t;

  // divide by three through a reciprocal, exact for any COORD_BITS+1 bit value
  localparam int DIV3_SHIFT = COORD_BITS + 2;
  localparam int DIV3_MUL   = ((1 << DIV3_SHIFT) + 2) / 3;
  localparam int DIV3_PROD  = 2 * COORD_BITS + 3;

  function automatic logic [COORD_BITS-1:0] div3(input logic [COORD_BITS:0] v);
    logic [DIV3_PROD-1:0] prod;
    prod = DIV3_PROD'(v) * DIV3_PROD'(DIV3_MUL);
    return prod[DIV3_SHIFT +: COORD_BITS];
  endfunction

  // horizontal bounds [w/3, 2w/3)
  function automatic logic [COORD_BITS-1:0] x_lo_of(input logic [COORD_BITS-1:0] w);
    return div3({1'b0, w});
  endfunction

  function automatic logic [COORD_BITS-1:0] x_hi_of(input logic [COORD_BITS-1:0] w);
    return div3({w, 1'b0});
  endfunction

  // vertical bounds [h/2, 3h/4)
  function automatic logic [COORD_BITS-1:0] y_lo_of(input logic [COORD_BITS-1:0] h);
    return COORD_BITS'(h >> 1);
  endfunction

  function automatic logic [COORD_BITS-1:0] y_hi_of(input logic [COORD_BITS-1:0] h);
    logic [COORD_BITS+1:0] h3;
    h3 = {h, 1'b0} + (COORD_BITS+2)'(h);
    return h3[COORD_BITS+1:2];
  endfunction

endpackage

`default_nettype wire

[hdl/rcbs_pix_if.sv]
// ----------------------------------------------------------------------------
// rcbs_pix_if
// Input channel: pixels and step-end commands with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcbs_pix_if;
  logic                               valid;
  logic                               ready;
  rcbs_pkg::cmd_t                     cmd;
  logic [rcbs_pkg::COORD_BITS-1:0]    pixel_x;
  logic [rcbs_pkg::COORD_BITS-1:0]    pixel_y;
  logic [rcbs_pkg::COLOUR_BITS-1:0]   red_value;
  logic [rcbs_pkg::COLOUR_BITS-1:0]   green_value;
  logic [rcbs_pkg::COLOUR_BITS-1:0]   blue_value;

  modport source (output valid, cmd, pixel_x, pixel_y, red_value, green_value,
                  blue_value, input ready);
  modport sink   (input valid, cmd, pixel_x, pixel_y, red_value, green_value,
                  blue_value, output ready);
endinterface

`default_nettype wire

[hdl/rcbs_res_if.sv]
// ----------------------------------------------------------------------------
// rcbs_res_if
// Result channel: wheel speed commands and detected colour with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcbs_res_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [rcbs_pkg::SPEED_BITS-1:0]  left_wheel;
  logic signed [rcbs_pkg::SPEED_BITS-1:0]  right_wheel;
  rcbs_pkg::blob_t                         blob_color;

  modport source (output valid, left_wheel, right_wheel, blob_color, input ready);
  modport sink   (input valid, left_wheel, right_wheel, blob_color, output ready);
endinterface

`default_nettype wire

[hdl/rcbs_cfg_if.sv]
// ----------------------------------------------------------------------------
// rcbs_cfg_if
// Configuration write channel: register index and data with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcbs_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [rcbs_pkg::REG_INDEX_BITS-1:0]   reg_index;
  logic [rcbs_pkg::CFG_DATA_BITS-1:0]    data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

`default_nettype wire

[hdl/rcbs_config.sv]
// ----------------------------------------------------------------------------
// rcbs_config
// Register file; keeps the search window bounds worked out from frame size.
// ----------------------------------------------------------------------------
`default_nettype none

module rcbs_config (
  input  logic           clk,
  input  logic           rst,
  rcbs_cfg_if.sink       cfg,
  output rcbs_pkg::cfg_t settings
);
  import rcbs_pkg::*;

  logic                  wr;
  logic [COORD_BITS-1:0] w_in;
  logic [COORD_BITS-1:0] h_in;

  // writes are always taken
  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid;

  // frame size masked to coordinate width
  assign w_in = COORD_BITS'(cfg.data[FRAME_BITS-1:0]);
  assign h_in = COORD_BITS'(cfg.data[FRAME_BITS-1:0]);

  // register writes, bounds updated with the frame size
  always_ff @(posedge clk) begin
    if (rst) begin
      settings.x_lo       <= x_lo_of(COORD_BITS'(FRAME_WIDTH_RESET));
      settings.x_hi       <= x_hi_of(COORD_BITS'(FRAME_WIDTH_RESET));
      settings.y_lo       <= y_lo_of(COORD_BITS'(FRAME_HEIGHT_RESET));
      settings.y_hi       <= y_hi_of(COORD_BITS'(FRAME_HEIGHT_RESET));
      settings.stop_ticks <= STOP_TICKS_RESET;
      settings.hold_ticks <= HOLD_TICKS_RESET;
      settings.turn_speed <= TURN_SPEED_RESET;
    end else if (wr) begin
      unique case (cfg.reg_index)
        REG_FRAME_WIDTH: begin
          settings.x_lo <= x_lo_of(w_in);
          settings.x_hi <= x_hi_of(w_in);
        end
        REG_FRAME_HEIGHT: begin
          settings.y_lo <= y_lo_of(h_in);
          settings.y_hi <= y_hi_of(h_in);
        end
        REG_STOP_TICKS: settings.stop_ticks <= cfg.data[TICK_BITS-1:0];
        REG_HOLD_TICKS: settings.hold_ticks <= cfg.data[TICK_BITS-1:0];
        REG_TURN_SPEED: settings.turn_speed <= cfg.data[TURN_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/roi_color_blob_seek_control.sv]
// ----------------------------------------------------------------------------
// roi_color_blob_seek_control
// Sums colour inside a window of each frame and steers a robot towards a blob.
// ----------------------------------------------------------------------------
//
//   channel  dir  carries                                   handshake
//   pix      in   cmd, pixel_x, pixel_y, red/green/blue     valid/ready
//   res      out  left_wheel, right_wheel, blob_color       valid/ready
//   cfg      in   reg_index, data                           valid/ready
//
// One request per clock is taken. A request passes through the input register:
// pixels update the sums there and step ends load the result register, from
// which the result is offered on res with valid set.
// A pixel in the input register never holds it up; a step end waits there,
// blocking new requests, only while the sink holds back an earlier result.
// Synchronous reset clears sums, pause count and valid flags; cfg writes act next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module roi_color_blob_seek_control (
  input  logic       clk,
  input  logic       rst,
  rcbs_pix_if.sink   pix,
  rcbs_res_if.source res,
  rcbs_cfg_if.sink   cfg
);
  import rcbs_pkg::*;

  cfg_t                  settings;

  // input register
  logic                  s1_valid;
  cmd_t                  s1_cmd;
  logic [COORD_BITS-1:0] s1_x;
  logic [COORD_BITS-1:0] s1_y;
  logic [COLOUR_BITS-1:0] s1_r;
  logic [COLOUR_BITS-1:0] s1_g;
  logic [COLOUR_BITS-1:0] s1_b;

  // state
  logic [SUM_BITS-1:0]   red_sum;
  logic [SUM_BITS-1:0]   green_sum;
  logic [SUM_BITS-1:0]   blue_sum;
  logic [TICK_BITS-1:0]  pause_count;

  // result register
  logic                        out_valid;
  logic signed [SPEED_BITS-1:0] out_left;
  logic signed [SPEED_BITS-1:0] out_right;
  blob_t                       out_color;

  // control
  logic                  s1_step;
  logic                  s1_pixel;
  logic                  s1_go;
  logic                  in_window;

  // step decision
  logic [TICK_BITS-1:0]  pause_dec;
  logic [TICK_BITS-1:0]  pause_next;
  logic signed [SPEED_BITS-1:0] turn_left;
  logic signed [SPEED_BITS-1:0] turn_right;
  logic signed [SPEED_BITS-1:0] left_next;
  logic signed [SPEED_BITS-1:0] right_next;
  blob_t                 color_next;

  // saturated sums
  logic [SUM_BITS-1:0]   red_add;
  logic [SUM_BITS-1:0]   green_add;
  logic [SUM_BITS-1:0]   blue_add;

  function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] acc,
                                                   input logic [COLOUR_BITS-1:0] v);
    logic [SUM_BITS:0] s;
    s = {1'b0, acc} + (SUM_BITS+1)'(v);
    return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
  endfunction

  // a exceeds three times both b and c
  function automatic logic dominates(input logic [SUM_BITS-1:0] a,
                                     input logic [SUM_BITS-1:0] b,
                                     input logic [SUM_BITS-1:0] c);
    logic [SUM_BITS+1:0] b3;
    logic [SUM_BITS+1:0] c3;
    logic [SUM_BITS+1:0] ax;
    b3 = {b, 1'b0} + (SUM_BITS+2)'(b);
    c3 = {c, 1'b0} + (SUM_BITS+2)'(c);
    ax = (SUM_BITS+2)'(a);
    return (ax > b3) && (ax > c3);
  endfunction

  rcbs_config u_config (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .settings (settings)
  );

  // flow control
  assign s1_step  = s1_valid && ((s1_cmd == CMD_STEP_FRAME) || (s1_cmd == CMD_STEP_NOFRAME));
  assign s1_pixel = s1_valid && (s1_cmd == CMD_PIXEL);
  assign s1_go    = !s1_step || !out_valid || res.ready;
  assign pix.ready = s1_go;

  // input register payload
  always_ff @(posedge clk) begin
    if (s1_go) begin
      s1_cmd <= pix.cmd;
      s1_x   <= pix.pixel_x;
      s1_y   <= pix.pixel_y;
      s1_r   <= pix.red_value;
      s1_g   <= pix.green_value;
      s1_b   <= pix.blue_value;
    end
  end

  // window test and accumulation
  assign in_window = (s1_x >= settings.x_lo) && (s1_x < settings.x_hi) &&
                     (s1_y >= settings.y_lo) && (s1_y < settings.y_hi);
  assign red_add   = sat_add(red_sum, s1_r);
  assign green_add = sat_add(green_sum, s1_g);
  assign blue_add  = sat_add(blue_sum, s1_b);

  // step-end control law
  assign pause_dec  = (pause_count != '0) ? pause_count - TICK_BITS'(1) : pause_count;
  assign turn_right = SPEED_BITS'(settings.turn_speed);
  assign turn_left  = SPEED_BITS'(0) - SPEED_BITS'(settings.turn_speed);

  always_comb begin
    pause_next = pause_dec;
    left_next  = '0;
    right_next = '0;
    color_next = BLOB_NONE;
    priority if (pause_dec > settings.stop_ticks) begin
      left_next  = '0;
    end else if (pause_dec != '0) begin
      left_next  = turn_left;
      right_next = turn_right;
    end else if (s1_cmd == CMD_STEP_NOFRAME) begin
      left_next  = '0;
    end else begin
      priority if (dominates(red_sum, green_sum, blue_sum)) begin
        color_next = BLOB_RED;
      end else if (dominates(green_sum, red_sum, blue_sum)) begin
        color_next = BLOB_GREEN;
      end else if (dominates(blue_sum, red_sum, green_sum)) begin
        color_next = BLOB_BLUE;
      end else begin
        color_next = BLOB_NONE;
      end
      if (color_next == BLOB_NONE) begin
        left_next  = turn_left;
        right_next = turn_right;
      end else begin
        pause_next = settings.hold_ticks;
      end
    end
  end

  // control state and sums
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      red_sum     <= '0;
      green_sum   <= '0;
      blue_sum    <= '0;
      pause_count <= '0;
    end else begin
      if (s1_go) begin
        s1_valid <= pix.valid;
      end
      if (s1_pixel && in_window) begin
        red_sum   <= red_add;
        green_sum <= green_add;
        blue_sum  <= blue_add;
      end
      if (s1_step && s1_go) begin
        red_sum     <= '0;
        green_sum   <= '0;
        blue_sum    <= '0;
        pause_count <= pause_next;
        out_valid   <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (s1_step && s1_go) begin
      out_left  <= left_next;
      out_right <= right_next;
      out_color <= color_next;
    end
  end

  assign res.valid       = out_valid;
  assign res.left_wheel  = out_left;
  assign res.right_wheel = out_right;
  assign res.blob_color  = out_color;

endmodule

`default_nettype wire

[bench/tb_roi_color_blob_seek_control.sv]
// ----------------------------------------------------------------------------
// tb_roi_color_blob_seek_control
// Self-checking bench for the colour blob seek control. Directed frames probe
// the window edges, every command, each decision branch and the tie rule;
// random frames then run under changing settings with bursty requests, a
// stalling result sink, one long sink hold-off and one long pause drain.
// ----------------------------------------------------------------------------

import rcbs_pkg::*;

// one wheel and colour decision
typedef struct packed {
  logic [SPEED_BITS-1:0] left_wheel;
  logic [SPEED_BITS-1:0] right_wheel;
  blob_t                 blob_color;
} steer_t;

// predicts the steering decisions and checks them in order
class steer_scoreboard;
  logic [FRAME_BITS-1:0] width_reg;
  logic [FRAME_BITS-1:0] height_reg;
  logic [TICK_BITS-1:0]  stop_reg;
  logic [TICK_BITS-1:0]  hold_reg;
  logic [TURN_BITS-1:0]  turn_reg;
  logic [SUM_BITS-1:0]   red_total;
  logic [SUM_BITS-1:0]   green_total;
  logic [SUM_BITS-1:0]   blue_total;
  logic [TICK_BITS-1:0]  pause_ticks;
  steer_t                expected_steer[$];
  int                    failures;
  int                    mismatches;

  function new();
    width_reg   = FRAME_WIDTH_RESET;
    height_reg  = FRAME_HEIGHT_RESET;
    stop_reg    = STOP_TICKS_RESET;
    hold_reg    = HOLD_TICKS_RESET;
    turn_reg    = TURN_SPEED_RESET;
    red_total   = '0;
    green_total = '0;
    blue_total  = '0;
    pause_ticks = '0;
    failures    = 0;
    mismatches  = 0;
  endfunction

  function int pending();
    return expected_steer.size();
  endfunction

  // unused indexes are dropped, values keep the register width
  function void note_config(logic [REG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_FRAME_WIDTH:  width_reg  = data[FRAME_BITS-1:0];
      REG_FRAME_HEIGHT: height_reg = data[FRAME_BITS-1:0];
      REG_STOP_TICKS:   stop_reg   = data[TICK_BITS-1:0];
      REG_HOLD_TICKS:   hold_reg   = data[TICK_BITS-1:0];
      REG_TURN_SPEED:   turn_reg   = data[TURN_BITS-1:0];
      default: ;
    endcase
  endfunction

  // saturating colour accumulation
  function logic [SUM_BITS-1:0] sat_add(logic [SUM_BITS-1:0] acc, logic [COLOUR_BITS-1:0] v);
    logic [SUM_BITS:0] s;
    s = {1'b0, acc} + v;
    return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
  endfunction

  // strictly more than three times each rival
  function bit beats(logic [SUM_BITS-1:0] a, logic [SUM_BITS-1:0] b, logic [SUM_BITS-1:0] c);
    logic [SUM_BITS+1:0] aa;
    logic [SUM_BITS+1:0] bb;
    logic [SUM_BITS+1:0] cc;
    aa = a;
    bb = b;
    cc = c;
    return (aa > 3 * bb) && (aa > 3 * cc);
  endfunction

  function void note_request(cmd_t cmd, logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                             logic [COLOUR_BITS-1:0] r, logic [COLOUR_BITS-1:0] g,
                             logic [COLOUR_BITS-1:0] b);
    int unsigned w;
    int unsigned h;
    int unsigned px;
    int unsigned py;
    steer_t      want;
    w  = width_reg;
    h  = height_reg;
    px = x;
    py = y;
    // pixels only feed the sums, and only inside the window
    if (cmd == CMD_PIXEL) begin
      if (px >= w / 3 && px < (2 * w) / 3 && py >= h / 2 && py < (3 * h) / 4) begin
        red_total   = sat_add(red_total, r);
        green_total = sat_add(green_total, g);
        blue_total  = sat_add(blue_total, b);
      end
      return;
    end
    if (cmd == CMD_UNUSED) return;

    // step end: pause countdown, then stop, turn or classify
    if (pause_ticks != 0) pause_ticks--;
    want.left_wheel  = '0;
    want.right_wheel = '0;
    want.blob_color  = BLOB_NONE;
    if (pause_ticks > stop_reg) begin
    end else if (pause_ticks != 0) begin
      want.left_wheel  = SPEED_BITS'(0) - SPEED_BITS'(turn_reg);
      want.right_wheel = SPEED_BITS'(turn_reg);
    end else if (cmd == CMD_STEP_NOFRAME) begin
    end else begin
      if (beats(red_total, green_total, blue_total))
        want.blob_color = BLOB_RED;
      else if (beats(green_total, red_total, blue_total))
        want.blob_color = BLOB_GREEN;
      else if (beats(blue_total, red_total, green_total))
        want.blob_color = BLOB_BLUE;
      if (want.blob_color == BLOB_NONE) begin
        want.left_wheel  = SPEED_BITS'(0) - SPEED_BITS'(turn_reg);
        want.right_wheel = SPEED_BITS'(turn_reg);
      end else begin
        pause_ticks = hold_reg;
      end
    end
    red_total   = '0;
    green_total = '0;
    blue_total  = '0;
    expected_steer.push_back(want);
  endfunction

  function void check_steer(logic [SPEED_BITS-1:0] left, logic [SPEED_BITS-1:0] right,
                            blob_t colour);
    steer_t want;
    if (expected_steer.size() == 0) begin
      failures++;
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: left %0d right %0d colour %0d",
                 $signed(left), $signed(right), colour);
      return;
    end
    want = expected_steer.pop_front();
    if (left !== want.left_wheel || right !== want.right_wheel ||
        colour !== want.blob_color) begin
      failures++;
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: expected left %0d right %0d colour %0d, got left %0d right %0d colour %0d",
                 $signed(want.left_wheel), $signed(want.right_wheel), want.blob_color,
                 $signed(left), $signed(right), colour);
    end
  endfunction

  function void close_out();
    if (expected_steer.size() != 0) begin
      failures++;
      $display("%0d expected results never arrived", expected_steer.size());
    end
  endfunction
endclass

module tb_roi_color_blob_seek_control;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SINK_OPEN     = 0;
  localparam int SINK_RANDOM   = 1;
  localparam int SINK_PERIODIC = 2;
  localparam int SCHEME_RED    = 0;
  localparam int SCHEME_GREEN  = 1;
  localparam int SCHEME_BLUE   = 2;
  localparam int SCHEME_MIXED  = 3;
  localparam int SCHEME_BORDER = 4;

  logic clk;
  logic rst;

  rcbs_pix_if pix ();
  rcbs_res_if res ();
  rcbs_cfg_if cfg ();

  roi_color_blob_seek_control u_top (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .res (res),
    .cfg (cfg)
  );

  steer_scoreboard sb;
  int              cycle_count   = 0;
  int              item_count    = 0;
  int              burst_left    = 0;
  int              gap_max       = 0;
  int              hold_off_left = 0;
  bit              sink_open     = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[roi_color_blob_seek_control] ERROR");
    $finish;
  end

  // accepted requests, results and register writes
  always @(posedge clk) begin
    if (!rst && pix.valid && pix.ready)
      sb.note_request(pix.cmd, pix.pixel_x, pix.pixel_y, pix.red_value, pix.green_value,
                      pix.blue_value);
    if (!rst && res.valid && res.ready)
      sb.check_steer(res.left_wheel, res.right_wheel, res.blob_color);
    if (!rst && cfg.valid && cfg.ready)
      sb.note_config(cfg.reg_index, cfg.data);
  end

  // result sink: own stall pattern, long hold-off on request
  initial begin : result_sink
    int mode;
    int mode_left;
    int tick;
    mode      = SINK_OPEN;
    mode_left = 0;
    tick      = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (mode_left == 0) begin
        mode      = $urandom_range(SINK_PERIODIC, SINK_OPEN);
        mode_left = $urandom_range(200, 20);
      end
      mode_left--;
      if (hold_off_left > 0) begin
        hold_off_left--;
        res.ready <= 1'b0;
      end else if (sink_open || mode == SINK_OPEN) begin
        res.ready <= 1'b1;
      end else if (mode == SINK_RANDOM) begin
        res.ready <= ($urandom_range(99, 0) < 60);
      end else begin
        res.ready <= ((tick % 7) >= 3);
      end
    end
  end

  // one request, in bursts with random gaps between them
  task automatic send_request(cmd_t c, logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                              logic [COLOUR_BITS-1:0] r, logic [COLOUR_BITS-1:0] g,
                              logic [COLOUR_BITS-1:0] b);
    int gaps;
    if (burst_left == 0) begin
      gaps = (gap_max == 0) ? 0 : $urandom_range(gap_max, 1);
      if (gaps > 0) begin
        pix.valid <= 1'b0;
        repeat (gaps) @(posedge clk);
      end
      burst_left = $urandom_range(24, 1);
    end
    pix.valid       <= 1'b1;
    pix.cmd         <= c;
    pix.pixel_x     <= x;
    pix.pixel_y     <= y;
    pix.red_value   <= r;
    pix.green_value <= g;
    pix.blue_value  <= b;
    do @(posedge clk); while (pix.ready !== 1'b1);
    burst_left--;
    if (c != CMD_UNUSED) item_count++;
  endtask

  task automatic step_end(cmd_t c);
    send_request(c, COORD_BITS'($urandom), COORD_BITS'($urandom), COLOUR_BITS'($urandom),
                 COLOUR_BITS'($urandom), COLOUR_BITS'($urandom));
  endtask

  // stop sending and wait until every result is in and the pipe is empty
  task automatic settle();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // all five registers, spare bits set at random, sometimes a spare index
  task automatic write_settings(logic [FRAME_BITS-1:0] w, logic [FRAME_BITS-1:0] h,
                                logic [TICK_BITS-1:0] stop, logic [TICK_BITS-1:0] hold,
                                logic [TURN_BITS-1:0] turn);
    logic [REG_INDEX_BITS-1:0] idx [5];
    logic [CFG_DATA_BITS-1:0]  val [5];
    idx = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_STOP_TICKS, REG_HOLD_TICKS, REG_TURN_SPEED};
    val[0] = {4'($urandom), w};
    val[1] = {4'($urandom), h};
    val[2] = stop;
    val[3] = hold;
    val[4] = {12'($urandom), turn};
    for (int i = 0; i < 5; i++) begin
      cfg.valid     <= 1'b1;
      cfg.reg_index <= idx[i];
      cfg.data      <= val[i];
      do @(posedge clk); while (cfg.ready !== 1'b1);
    end
    if ($urandom_range(1, 0) == 1) begin
      cfg.reg_index <= REG_INDEX_BITS'(REG_TURN_SPEED + $urandom_range(3, 1));
      cfg.data      <= CFG_DATA_BITS'($urandom);
      do @(posedge clk); while (cfg.ready !== 1'b1);
    end
    cfg.valid <= 1'b0;
  endtask

  // a run of pixels, mostly in the window, closed by a step end
  task automatic send_frame(int n_pix, bit with_frame);
    int unsigned            xl;
    int unsigned            xh;
    int unsigned            yl;
    int unsigned            yh;
    int                     scheme;
    int                     roll;
    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
    logic [COLOUR_BITS-1:0] cr;
    logic [COLOUR_BITS-1:0] cg;
    logic [COLOUR_BITS-1:0] cb;
    xl = sb.width_reg / 3;
    xh = (2 * sb.width_reg) / 3;
    yl = sb.height_reg / 2;
    yh = (3 * sb.height_reg) / 4;
    scheme = $urandom_range(SCHEME_BORDER, SCHEME_RED);
    for (int i = 0; i < n_pix; i++) begin
      roll = $urandom_range(99, 0);
      x = (xh > xl) ? COORD_BITS'($urandom_range(xh - 1, xl)) : COORD_BITS'($urandom);
      y = (yh > yl) ? COORD_BITS'($urandom_range(yh - 1, yl)) : COORD_BITS'($urandom);
      if (roll < 10) begin
        x = COORD_BITS'($urandom);
        y = COORD_BITS'($urandom);
      end
      cr = COLOUR_BITS'($urandom_range(45, 0));
      cg = COLOUR_BITS'($urandom_range(45, 0));
      cb = COLOUR_BITS'($urandom_range(45, 0));
      case (scheme)
        SCHEME_RED:   cr = COLOUR_BITS'($urandom_range(255, 140));
        SCHEME_GREEN: cg = COLOUR_BITS'($urandom_range(255, 140));
        SCHEME_BLUE:  cb = COLOUR_BITS'($urandom_range(255, 140));
        SCHEME_MIXED: begin
          cr = COLOUR_BITS'($urandom);
          cg = COLOUR_BITS'($urandom);
          cb = COLOUR_BITS'($urandom);
        end
        default: begin
          // close to the three-times line
          cr = COLOUR_BITS'($urandom_range(120, 90));
          cg = COLOUR_BITS'($urandom_range(40, 30));
          cb = COLOUR_BITS'($urandom_range(40, 30));
        end
      endcase
      if (roll >= 96)
        send_request(CMD_UNUSED, x, y, cr, cg, cb);
      else
        send_request(CMD_PIXEL, x, y, cr, cg, cb);
    end
    step_end(with_frame ? CMD_STEP_FRAME : CMD_STEP_NOFRAME);
  endtask

  // stimulus
  initial begin : stimulus
    int                    goal;
    int                    n_pix;
    logic [FRAME_BITS-1:0] w;
    logic [FRAME_BITS-1:0] h;
    logic [TICK_BITS-1:0]  stop;
    logic [TICK_BITS-1:0]  hold;
    sb = new();
    rst             <= 1'b1;
    pix.valid       <= 1'b0;
    pix.cmd         <= CMD_PIXEL;
    pix.pixel_x     <= '0;
    pix.pixel_y     <= '0;
    pix.red_value   <= '0;
    pix.green_value <= '0;
    pix.blue_value  <= '0;
    cfg.valid       <= 1'b0;
    cfg.reg_index   <= REG_FRAME_WIDTH;
    cfg.data        <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: window x 17..33, y 19..28, edges on both sides
    send_request(CMD_PIXEL, 12'd0, 12'd0, 8'd255, 8'd255, 8'd255);
    send_request(CMD_PIXEL, 12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255);
    send_request(CMD_PIXEL, 12'd16, 12'd19, 8'd255, 8'd255, 8'd255);
    send_request(CMD_PIXEL, 12'd17, 12'd18, 8'd255, 8'd255, 8'd255);
    send_request(CMD_PIXEL, 12'd34, 12'd20, 8'd255, 8'd255, 8'd255);
    send_request(CMD_PIXEL, 12'd17, 12'd29, 8'd255, 8'd255, 8'd255);
    send_request(CMD_PIXEL, 12'd17, 12'd19, 8'd255, 8'd0, 8'd0);
    send_request(CMD_PIXEL, 12'd33, 12'd28, 8'd200, 8'd10, 8'd5);
    send_request(CMD_UNUSED, 12'd20, 12'd20, 8'd0, 8'd255, 8'd0);
    step_end(CMD_STEP_FRAME);
    step_end(CMD_STEP_FRAME);
    step_end(CMD_STEP_NOFRAME);

    // count the pause down through the stopped and turning stretches
    settle();
    repeat (sb.pause_ticks) step_end(CMD_STEP_NOFRAME);
    settle();

    // one tick of hold, fastest turn
    write_settings(12'd52, 12'd39, 16'd0, 16'd1, 4'd15);
    send_request(CMD_PIXEL, 12'd20, 12'd20, 8'd0, 8'd255, 8'd0);
    step_end(CMD_STEP_FRAME);
    step_end(CMD_STEP_FRAME);
    send_request(CMD_PIXEL, 12'd30, 12'd25, 8'd0, 8'd0, 8'd255);
    step_end(CMD_STEP_FRAME);
    step_end(CMD_STEP_NOFRAME);
    send_request(CMD_PIXEL, 12'd25, 12'd22, 8'd128, 8'd128, 8'd128);
    step_end(CMD_STEP_FRAME);
    // exactly three times is not a win, one more is
    send_request(CMD_PIXEL, 12'd25, 12'd22, 8'd3, 8'd1, 8'd0);
    step_end(CMD_STEP_FRAME);
    send_request(CMD_PIXEL, 12'd25, 12'd22, 8'd4, 8'd1, 8'd1);
    step_end(CMD_STEP_FRAME);

    // random frames under changing settings
    for (int p = 0; p < 10; p++) begin
      settle();
      if (p == 0) begin
        write_settings(12'd3, 12'd4, 16'd0, 16'd0, 4'd0);
      end else if (p == 1) begin
        write_settings(12'd4095, 12'd4095, 16'hFFFF, 16'd3, 4'd15);
      end else begin
        w    = ($urandom_range(3, 0) == 0) ? 12'($urandom_range(4095, 3))
                                           : 12'($urandom_range(60, 3));
        h    = ($urandom_range(3, 0) == 0) ? 12'($urandom_range(4095, 4))
                                           : 12'($urandom_range(60, 4));
        stop = 16'($urandom_range(4, 0));
        hold = 16'($urandom_range(8, 0));
        if ($urandom_range(4, 0) == 0) begin
          stop = STOP_TICKS_RESET;
          hold = HOLD_TICKS_RESET;
        end
        write_settings(w, h, stop, hold, 4'($urandom));
      end
      gap_max = (p % 3 == 0) ? 0 : $urandom_range(8, 2);
      // sink holds off while step ends keep coming
      if (p == 5) hold_off_left = 250;
      goal = item_count + 65;
      while (item_count < goal) begin
        n_pix = (p == 5) ? $urandom_range(2, 0) : $urandom_range(10, 1);
        if (p != 5 && $urandom_range(14, 0) == 0) n_pix = 0;
        send_frame(n_pix, $urandom_range(99, 0) < 85);
      end
    end

    // long hold: detect, then count the whole pause down
    settle();
    write_settings(12'd30, 12'd20, 16'd57, 16'd60, 4'($urandom));
    sink_open = 1'b1;
    gap_max   = 0;
    repeat (sb.pause_ticks) step_end(CMD_STEP_NOFRAME);
    repeat (4) send_request(CMD_PIXEL, 12'd12, 12'd11, 8'd250, 8'd3, 8'd7);
    step_end(CMD_STEP_FRAME);
    repeat (60) step_end(CMD_STEP_NOFRAME);
    send_request(CMD_PIXEL, 12'd15, 12'd12, 8'd5, 8'd5, 8'd240);
    step_end(CMD_STEP_FRAME);

    settle();
    sb.close_out();
    if (sb.failures == 0)
      $display("[roi_color_blob_seek_control] OK");
    else
      $display("[roi_color_blob_seek_control] ERROR");
    $finish;
  end

endmodule
